@@ rtl/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int ADDR_W    = 32;
  localparam int REQ_W     = 24;
  localparam int LIMIT_W   = 25;
  localparam int SPLIT_W   = 11;
  localparam int LEN_W     = 25;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT  = 2'd2;

  localparam logic [ADDR_W-1:0]  RST_HEAP_BASE  = 32'd0;
  localparam logic [LIMIT_W-1:0] RST_HEAP_LIMIT = 25'd16777216;
  localparam logic [SPLIT_W-1:0] RST_MIN_SPLIT  = 11'd32;
  localparam logic [SPLIT_W-1:0] LEAST_SPLIT    = 11'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] block_address;
    logic [REQ_W-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    logic                copy_needed;
    logic [ADDR_W-1:0]   copy_source;
    logic [LEN_W-1:0]    copy_length;
  } out_item_t;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator: block table walk, split, coalesce and break control.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_item  (op, block_address, request_size)
//   out     | output    | out_valid / out_ready | out_item (address, status, copy info)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time; in_ready is high only while the sequencer is idle.
// An alloc walks the table from the list head; a free walks it first to look up the block;
// a realloc that moves does the lookup walk, then the alloc walk, then the free.
// The walks read one table entry per cycle from the single read port of the table RAMs.
// Reset clears the slot map, the break and the list head; table contents need no clearing.
// A finished item waits in the output register; the next item is accepted meanwhile,
// and its result holds in the finish step until the output register drains.
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ffha_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ffha_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]          cfg_data
);

  import ffha_pkg::*;

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int IW  = AW + 1;
  localparam int MW  = (SIZE_BITS + 1 > LIMIT_W) ? SIZE_BITS + 1 : LIMIT_W;
  localparam int LW  = MW + 1;
  localparam int CW  = (LW > ADDR_W) ? LW : ADDR_W;
  localparam int RW  = (SIZE_BITS < REQ_W) ? SIZE_BITS : REQ_W;
  localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);

  typedef enum logic [18:0] {
    S_IDLE = 19'd1,
    S_LK   = 19'd2,
    S_RC   = 19'd4,
    S_RF2  = 19'd8,
    S_AW   = 19'd16,
    S_G0   = 19'd32,
    S_G1   = 19'd64,
    S_S1   = 19'd128,
    S_S2   = 19'd256,
    S_S3   = 19'd512,
    S_AF   = 19'd1024,
    S_FR0  = 19'd2048,
    S_FR1  = 19'd4096,
    S_FR2  = 19'd8192,
    S_FR2B = 19'd16384,
    S_FR3  = 19'd32768,
    S_FN   = 19'd65536,
    S_FN2  = 19'd131072,
    S_FIN  = 19'd262144
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]   heap_base;
  logic [LIMIT_W-1:0]  heap_limit;
  logic [SPLIT_W-1:0]  min_split;

  logic [MAX_BLOCKS-1:0] slot_in_use;
  logic [IW-1:0]         first;
  logic [LW-1:0]         brk;
  logic [IW-1:0]         spare;
  logic                  spare_ok;
  logic [IW-1:0]         spare_enc;

  logic              is_free;
  logic              alloc_path;
  logic              move;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] off_r;
  logic              in_range;
  logic [LW-1:0]     s;
  logic [IW-1:0]     b;
  logic [IW-1:0]     last;
  logic [IW-1:0]     n;
  logic [IW-1:0]     ob;
  logic [LW-1:0]     boff;
  logic [LW-1:0]     bsize;
  logic [IW-1:0]     bnext;
  logic [IW-1:0]     bprev;
  logic [LW-1:0]     old_size;

  logic [ADDR_W-1:0]   res_addr;
  logic [STATUS_W-1:0] res_status;
  logic                res_copy;
  logic [ADDR_W-1:0]   res_src;
  logic [LEN_W-1:0]    res_len;

  logic [IW-1:0] rd_idx;
  logic [LW-1:0] r_off;
  logic [LW-1:0] r_size;
  logic          r_free;
  logic [IW-1:0] r_next;
  logic [IW-1:0] r_prev;

  logic [IW-1:0] wr_idx;
  logic          we_off, we_size, we_free, we_next, we_prev;
  logic [LW-1:0] wd_off, wd_size;
  logic          wd_free;
  logic [IW-1:0] wd_next, wd_prev;

  logic [RW-1:0]     req_m;
  logic [LW-1:0]     req_up;
  logic [LW-1:0]     s_in;
  logic [ADDR_W-1:0] off_in;
  logic [SPLIT_W-1:0] least;
  logic [LW-1:0]     rem;
  logic              split_ok;
  logic [LW-1:0]     fuse_sum;
  logic              fuse_ok;
  logic [LW:0]       grow_end;
  logic              grow_fail;
  logic              out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign req_m  = in_item.request_size[RW-1:0];
  assign req_up = (LW'(req_m) + LW'(3)) & ~LW'(3);
  assign s_in   = (req_m == '0) ? LW'(4) : req_up;
  assign off_in = in_item.block_address - heap_base;

  assign least    = (min_split < LEAST_SPLIT) ? LEAST_SPLIT : min_split;
  assign rem      = bsize - s;
  assign split_ok = (rem >= LW'(least)) && spare_ok;
  assign fuse_sum = bsize + r_size;
  assign fuse_ok  = (bnext != NIL) && r_free && (fuse_sum >= s);
  assign grow_end = {1'b0, brk} + {1'b0, s};
  assign grow_fail = (grow_end > (LW+1)'(heap_limit)) || !spare_ok;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    spare_enc = NIL;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!slot_in_use[i]) begin
        spare_enc = IW'(i);
      end
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  rd_idx = first;
      S_LK:    rd_idx = r_next;
      S_AW:    rd_idx = r_next;
      S_RC:    rd_idx = first;
      S_FR0:   rd_idx = b;
      S_FR1:   rd_idx = r_prev;
      S_FR3:   rd_idx = bnext;
      default: rd_idx = first;
    endcase
  end

  always_comb begin
    wr_idx  = b;
    we_off  = 1'b0;
    we_size = 1'b0;
    we_free = 1'b0;
    we_next = 1'b0;
    we_prev = 1'b0;
    wd_off  = '0;
    wd_size = '0;
    wd_free = 1'b0;
    wd_next = NIL;
    wd_prev = NIL;
    case (state)
      S_RC: begin
        if (fuse_ok) begin
          we_size = 1'b1;
          wd_size = fuse_sum;
          we_next = 1'b1;
          wd_next = r_next;
        end
      end
      S_RF2: begin
        wr_idx  = bnext;
        we_prev = (bnext != NIL);
        wd_prev = b;
      end
      S_G0: begin
        wr_idx  = spare;
        we_off  = !grow_fail;
        we_size = !grow_fail;
        we_free = !grow_fail;
        we_next = !grow_fail;
        we_prev = !grow_fail;
        wd_off  = brk;
        wd_size = s;
        wd_free = 1'b0;
        wd_next = NIL;
        wd_prev = last;
      end
      S_G1: begin
        wr_idx  = last;
        we_next = (last != NIL);
        wd_next = b;
      end
      S_S1: begin
        wr_idx  = spare;
        we_off  = split_ok;
        we_size = split_ok;
        we_free = split_ok;
        we_next = split_ok;
        we_prev = split_ok;
        wd_off  = boff + s;
        wd_size = rem;
        wd_free = 1'b1;
        wd_next = bnext;
        wd_prev = b;
      end
      S_S2: begin
        wr_idx  = bnext;
        we_prev = (bnext != NIL);
        wd_prev = n;
      end
      S_S3: begin
        we_next = 1'b1;
        wd_next = n;
        we_size = 1'b1;
        wd_size = s;
      end
      S_AF: begin
        we_free = 1'b1;
        wd_free = 1'b0;
      end
      S_FR1: begin
        we_free = 1'b1;
        wd_free = 1'b1;
      end
      S_FR2: begin
        wr_idx  = bprev;
        we_size = r_free;
        wd_size = fuse_sum;
        we_next = r_free;
        wd_next = bnext;
      end
      S_FR2B: begin
        wr_idx  = bnext;
        we_prev = (bnext != NIL);
        wd_prev = b;
      end
      S_FR3: begin
        wr_idx  = bprev;
        we_next = (bnext == NIL) && (bprev != NIL);
        wd_next = NIL;
      end
      S_FN: begin
        we_size = r_free;
        wd_size = fuse_sum;
        we_next = r_free;
        wd_next = r_next;
      end
      S_FN2: begin
        wr_idx  = n;
        we_prev = 1'b1;
        wd_prev = b;
      end
      default: begin
        wr_idx = b;
      end
    endcase
  end

  ffha_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_off_ram (
    .clk(clk), .we(we_off), .waddr(wr_idx[AW-1:0]), .wdata(wd_off),
    .raddr(rd_idx[AW-1:0]), .rdata(r_off)
  );

  ffha_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_size_ram (
    .clk(clk), .we(we_size), .waddr(wr_idx[AW-1:0]), .wdata(wd_size),
    .raddr(rd_idx[AW-1:0]), .rdata(r_size)
  );

  ffha_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_free_ram (
    .clk(clk), .we(we_free), .waddr(wr_idx[AW-1:0]), .wdata(wd_free),
    .raddr(rd_idx[AW-1:0]), .rdata(r_free)
  );

  ffha_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk(clk), .we(we_next), .waddr(wr_idx[AW-1:0]), .wdata(wd_next),
    .raddr(rd_idx[AW-1:0]), .rdata(r_next)
  );

  ffha_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_prev_ram (
    .clk(clk), .we(we_prev), .waddr(wr_idx[AW-1:0]), .wdata(wd_prev),
    .raddr(rd_idx[AW-1:0]), .rdata(r_prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= RST_HEAP_BASE;
      heap_limit <= RST_HEAP_LIMIT;
      min_split  <= RST_MIN_SPLIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAP_BASE:  heap_base  <= cfg_data;
        CFG_HEAP_LIMIT: heap_limit <= cfg_data[LIMIT_W-1:0];
        CFG_MIN_SPLIT:  min_split  <= cfg_data[SPLIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spare    <= '0;
      spare_ok <= 1'b1;
    end else begin
      spare    <= spare_enc;
      spare_ok <= ~&slot_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_in_use <= '0;
      first       <= NIL;
      brk         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            addr_r     <= in_item.block_address;
            off_r      <= off_in;
            in_range   <= CW'(off_in) < CW'(brk);
            s          <= s_in;
            b          <= first;
            last       <= NIL;
            move       <= 1'b0;
            is_free    <= (in_item.op == OP_FREE);
            alloc_path <= 1'b0;
            res_addr   <= '0;
            res_status <= ST_OK;
            res_copy   <= 1'b0;
            res_src    <= '0;
            res_len    <= '0;
            case (in_item.op)
              OP_ALLOC: begin
                alloc_path <= 1'b1;
                state      <= S_AW;
              end
              OP_FREE: begin
                state <= (in_item.block_address == '0) ? S_FIN : S_LK;
              end
              OP_REALLOC: begin
                alloc_path <= (in_item.block_address == '0);
                state      <= (in_item.block_address == '0) ? S_AW : S_LK;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_LK: begin
          if (b == NIL || !in_range) begin
            res_status <= ST_BAD_ADDR;
            state      <= S_FIN;
          end else if (CW'(r_off) == CW'(off_r)) begin
            boff  <= r_off;
            bsize <= r_size;
            bnext <= r_next;
            bprev <= r_prev;
            if (is_free) begin
              state <= S_FR0;
            end else if (r_size >= s) begin
              res_addr <= addr_r;
              state    <= S_S1;
            end else begin
              state <= S_RC;
            end
          end else begin
            b <= r_next;
          end
        end
        S_RC: begin
          if (fuse_ok) begin
            bsize    <= fuse_sum;
            bnext    <= r_next;
            slot_in_use[bnext[AW-1:0]] <= 1'b0;
            res_addr <= addr_r;
            state    <= S_RF2;
          end else begin
            ob         <= b;
            old_size   <= bsize;
            move       <= 1'b1;
            alloc_path <= 1'b1;
            b          <= first;
            last       <= NIL;
            state      <= S_AW;
          end
        end
        S_RF2: begin
          state <= S_S1;
        end
        S_AW: begin
          if (b == NIL) begin
            state <= S_G0;
          end else if (r_free && r_size >= s) begin
            boff  <= r_off;
            bsize <= r_size;
            bnext <= r_next;
            state <= S_S1;
          end else begin
            last <= b;
            b    <= r_next;
          end
        end
        S_G0: begin
          if (grow_fail) begin
            res_status <= ST_NO_SPACE;
            state      <= S_FIN;
          end else begin
            slot_in_use[spare[AW-1:0]] <= 1'b1;
            b     <= spare;
            boff  <= brk;
            bsize <= s;
            state <= S_G1;
          end
        end
        S_G1: begin
          if (last == NIL) begin
            first <= b;
          end
          brk   <= grow_end[LW-1:0];
          state <= S_AF;
        end
        S_S1: begin
          if (split_ok) begin
            slot_in_use[spare[AW-1:0]] <= 1'b1;
            n     <= spare;
            state <= S_S2;
          end else begin
            state <= alloc_path ? S_AF : S_FIN;
          end
        end
        S_S2: begin
          state <= S_S3;
        end
        S_S3: begin
          bsize <= s;
          state <= alloc_path ? S_AF : S_FIN;
        end
        S_AF: begin
          res_addr <= heap_base + ADDR_W'(boff);
          if (move) begin
            res_copy <= 1'b1;
            res_src  <= addr_r;
            res_len  <= (old_size < bsize) ? old_size[LEN_W-1:0] : bsize[LEN_W-1:0];
            b        <= ob;
            state    <= S_FR0;
          end else begin
            state <= S_FIN;
          end
        end
        S_FR0: begin
          state <= S_FR1;
        end
        S_FR1: begin
          bsize <= r_size;
          bnext <= r_next;
          bprev <= r_prev;
          state <= (r_prev == NIL) ? S_FR3 : S_FR2;
        end
        S_FR2: begin
          if (r_free) begin
            slot_in_use[b[AW-1:0]] <= 1'b0;
            b     <= bprev;
            bsize <= fuse_sum;
            bprev <= r_prev;
            state <= S_FR2B;
          end else begin
            state <= S_FR3;
          end
        end
        S_FR2B: begin
          state <= S_FR3;
        end
        S_FR3: begin
          if (bnext != NIL) begin
            state <= S_FN;
          end else begin
            if (bprev == NIL) begin
              first <= NIL;
            end
            brk <= (brk >= bsize) ? brk - bsize : '0;
            slot_in_use[b[AW-1:0]] <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FN: begin
          if (r_free) begin
            slot_in_use[bnext[AW-1:0]] <= 1'b0;
            n     <= r_next;
            state <= (r_next != NIL) ? S_FN2 : S_FIN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FN2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_item.result_address <= res_addr;
            out_item.status         <= res_status;
            out_item.copy_needed    <= res_copy;
            out_item.copy_source    <= res_src;
            out_item.copy_length    <= res_len;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while a request is in progress");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result loaded outside the finish step");

  a_spare_is_free: assert property (@(posedge clk) disable iff (rst)
    ((state == S_G0 && !grow_fail) || (state == S_S1 && split_ok))
      |-> !slot_in_use[spare[AW-1:0]])
    else $error("slot taken twice");

  a_break_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_G1 |=> brk <= LW'($past(heap_limit)))
    else $error("break grew past the heap limit");
`endif

endmodule

@@ sim/testbench.sv @@
// Testbench for the first-fit heap allocator: random and directed requests against a predictor.
`timescale 1ns / 1ps

module testbench;
  import ffha_pkg::*;

  localparam int SLOTS = 64;
  localparam int NIL = SLOTS;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 200;

  class alloc_scoreboard;
    bit [31:0] base;
    bit [24:0] limit;
    bit [10:0] split;
    bit [31:0] blk_off[SLOTS];
    bit [31:0] blk_size[SLOTS];
    bit blk_free[SLOTS];
    int blk_next[SLOTS];
    int blk_prev[SLOTS];
    bit slot_used[SLOTS];
    int head;
    bit [31:0] brk;
    out_item_t expected_q[$];

    function new();
      base = RST_HEAP_BASE;
      limit = RST_HEAP_LIMIT;
      split = RST_MIN_SPLIT;
      foreach (slot_used[i]) slot_used[i] = 0;
      head = NIL;
      brk = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_HEAP_BASE: base = data;
        CFG_HEAP_LIMIT: limit = data[24:0];
        CFG_MIN_SPLIT: split = data[10:0];
        default: ;
      endcase
    endfunction

    function int grab_slot();
      for (int i = 0; i < SLOTS; i++) if (!slot_used[i]) return i;
      return NIL;
    endfunction

    function longint unsigned rounded(logic [REQ_W-1:0] req);
      longint unsigned r;
      r = req;
      if (r == 0) r = 4;
      return (((r - 1) >> 2) << 2) + 4;
    endfunction

    function void carve(int b, longint unsigned s);
      longint unsigned rem, least;
      int n, nx;
      if (blk_size[b] < s) return;
      rem = blk_size[b] - s;
      least = (split < LEAST_SPLIT) ? LEAST_SPLIT : split;
      if (rem < least) return;
      n = grab_slot();
      if (n == NIL) return;
      nx = blk_next[b];
      slot_used[n] = 1;
      blk_off[n] = blk_off[b] + s[31:0];
      blk_size[n] = rem[31:0];
      blk_free[n] = 1;
      blk_next[n] = nx;
      blk_prev[n] = b;
      if (nx != NIL) blk_prev[nx] = n;
      blk_next[b] = n;
      blk_size[b] = s[31:0];
    endfunction

    function void merge_next(int b);
      int n, nn;
      n = blk_next[b];
      if (n == NIL || !blk_free[n]) return;
      nn = blk_next[n];
      blk_size[b] += blk_size[n];
      blk_next[b] = nn;
      if (nn != NIL) blk_prev[nn] = b;
      slot_used[n] = 0;
    endfunction

    function int locate(bit [31:0] addr);
      bit [31:0] off;
      int b;
      off = addr - base;
      b = head;
      for (int k = 0; k < SLOTS && b != NIL; k++) begin
        if (blk_off[b] == off && off < brk) return b;
        b = blk_next[b];
      end
      return NIL;
    endfunction

    function int place(longint unsigned s);
      int b, last, n;
      b = head;
      last = NIL;
      for (int k = 0; k < SLOTS && b != NIL; k++) begin
        if (blk_free[b] && blk_size[b] >= s) begin
          carve(b, s);
          blk_free[b] = 0;
          return b;
        end
        last = b;
        b = blk_next[b];
      end
      if (longint'(brk) + s > longint'(limit)) return NIL;
      n = grab_slot();
      if (n == NIL) return NIL;
      slot_used[n] = 1;
      blk_off[n] = brk;
      blk_size[n] = s[31:0];
      blk_free[n] = 0;
      blk_next[n] = NIL;
      blk_prev[n] = last;
      if (last != NIL) blk_next[last] = n;
      else head = n;
      brk = brk + s[31:0];
      return n;
    endfunction

    function void give_back(int b);
      int p;
      blk_free[b] = 1;
      p = blk_prev[b];
      if (p != NIL && blk_free[p]) begin
        merge_next(p);
        b = p;
      end
      if (blk_next[b] != NIL) begin
        merge_next(b);
        return;
      end
      p = blk_prev[b];
      if (p != NIL) blk_next[p] = NIL;
      else head = NIL;
      brk = (brk >= blk_size[b]) ? brk - blk_size[b] : 0;
      slot_used[b] = 0;
    endfunction

    function out_item_t note(in_item_t it);
      out_item_t e;
      longint unsigned s;
      int b, n, nx;
      bit [31:0] old_size;
      e = '0;
      s = rounded(it.request_size);
      if (it.op == OP_ALLOC || (it.op == OP_REALLOC && it.block_address == 0)) begin
        b = place(s);
        if (b == NIL) e.status = ST_NO_SPACE;
        else e.result_address = base + blk_off[b];
      end else if (it.op == OP_FREE) begin
        if (it.block_address != 0) begin
          b = locate(it.block_address);
          if (b == NIL) e.status = ST_BAD_ADDR;
          else give_back(b);
        end
      end else if (it.op == OP_REALLOC) begin
        b = locate(it.block_address);
        if (b == NIL) begin
          e.status = ST_BAD_ADDR;
        end else if (blk_size[b] >= s) begin
          carve(b, s);
          e.result_address = it.block_address;
        end else begin
          nx = blk_next[b];
          if (nx != NIL && blk_free[nx] &&
              longint'(blk_size[b]) + longint'(blk_size[nx]) >= s) begin
            merge_next(b);
            carve(b, s);
            e.result_address = it.block_address;
          end else begin
            old_size = blk_size[b];
            n = place(s);
            if (n == NIL) begin
              e.status = ST_NO_SPACE;
            end else begin
              e.result_address = base + blk_off[n];
              e.copy_needed = 1;
              e.copy_source = it.block_address;
              e.copy_length = LEN_W'((old_size < blk_size[n]) ? old_size : blk_size[n]);
              give_back(b);
            end
          end
        end
      end
      expected_q.push_back(e);
      return e;
    endfunction

    function bit check(out_item_t got, output string why);
      out_item_t e;
      why = "";
      if (expected_q.size() == 0) begin
        $sformat(why, "result with nothing expected: %h", got);
        return 0;
      end
      e = expected_q.pop_front();
      if (got.result_address !== e.result_address)
        why = {why, $sformatf(" result_address %h/%h", got.result_address, e.result_address)};
      if (got.status !== e.status)
        why = {why, $sformatf(" status %0d/%0d", got.status, e.status)};
      if (got.copy_needed !== e.copy_needed)
        why = {why, $sformatf(" copy_needed %b/%b", got.copy_needed, e.copy_needed)};
      if (got.copy_source !== e.copy_source)
        why = {why, $sformatf(" copy_source %h/%h", got.copy_source, e.copy_source)};
      if (got.copy_length !== e.copy_length)
        why = {why, $sformatf(" copy_length %0d/%0d", got.copy_length, e.copy_length)};
      return why == "";
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  bit [31:0] live_q[$];
  bit [31:0] dead_q[$];

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task report(string msg);
    $display("mismatch @%0t:%s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string why;
    if (!rst && out_valid && out_ready) begin
      if (!sb.check(out_item, why)) report(why);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (($urandom_range(255)) == 0) stall_mode = $urandom_range(3);
    case (stall_mode)
      0: out_ready = 1;
      1: out_ready = 1'($urandom_range(1));
      2: out_ready = ($urandom_range(3) == 0);
      default: out_ready = ($urandom_range(15) != 0);
    endcase
  end

  task drop_offset(bit [31:0] off);
    foreach (live_q[i]) begin
      if (live_q[i] == off) begin
        live_q.delete(i);
        break;
      end
    end
  endtask

  task send(logic [OP_W-1:0] op, logic [31:0] addr, logic [REQ_W-1:0] size);
    out_item_t e;
    in_item_t it;
    bit [31:0] off;
    if (burst_left == 0) begin
      in_valid = 0;
      if ($urandom_range(3) != 0) repeat ($urandom_range(6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    it.op = op;
    it.block_address = addr;
    it.request_size = size;
    in_item = it;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = sb.note(it);
    burst_left--;
    off = addr - sb.base;
    if (e.status == ST_OK) begin
      if (op == OP_ALLOC || (op == OP_REALLOC && addr == 0)) begin
        live_q.push_back(e.result_address - sb.base);
      end else if (op == OP_FREE && addr != 0) begin
        drop_offset(off);
        dead_q.push_back(off);
      end else if (op == OP_REALLOC && e.copy_needed) begin
        drop_offset(off);
        dead_q.push_back(off);
        live_q.push_back(e.result_address - sb.base);
      end
    end
    @(negedge clk);
  endtask

  task drain;
    in_valid = 0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task setup(logic [31:0] base, logic [31:0] limit, logic [31:0] split);
    drain();
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LIMIT, limit);
    write_reg(CFG_MIN_SPLIT, split);
  endtask

  function logic [REQ_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return REQ_W'($urandom_range(0, 200));
    if (r < 95) return REQ_W'($urandom_range(0, 4095));
    return REQ_W'($urandom());
  endfunction

  function logic [31:0] pick_live();
    return sb.base + live_q[$urandom_range(live_q.size() - 1)];
  endfunction

  task random_phase(int count, int alloc_pct);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        case ($urandom_range(4))
          0: send(2'd3, $urandom(), REQ_W'($urandom()));
          1: send(OP_FREE, $urandom(), pick_size());
          2: send(OP_REALLOC, $urandom(), pick_size());
          3: send(OP_FREE, 0, REQ_W'($urandom()));
          default: begin
            if (dead_q.size() != 0)
              send($urandom_range(1) ? OP_FREE : OP_REALLOC,
                   sb.base + dead_q[$urandom_range(dead_q.size() - 1)], pick_size());
            else
              send(OP_REALLOC, 0, pick_size());
          end
        endcase
      end else if (live_q.size() == 0 || $urandom_range(99) < alloc_pct) begin
        send(OP_ALLOC, 0, pick_size());
      end else if ($urandom_range(9) < 6) begin
        send(OP_FREE, pick_live(), REQ_W'($urandom()));
      end else begin
        send(OP_REALLOC, pick_live(), pick_size());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 0, 1);
    send(OP_ALLOC, 0, 5);
    send(OP_ALLOC, 0, 24'hFFFFFF);
    send(OP_ALLOC, 0, 100);
    send(OP_ALLOC, 0, 8);
    send(OP_FREE, 0, 0);
    send(OP_FREE, 32'd3, 0);
    send(OP_FREE, 32'hFFFFFFFF, 0);
    send(OP_REALLOC, 0, 8);
    send(2'd3, 32'hFFFFFFFF, 24'hFFFFFF);
    send(OP_FREE, 32'd12, 0);
    send(OP_REALLOC, 32'd12, 40);
    send(OP_FREE, 32'd4, 0);
    send(OP_FREE, 32'd4, 0);
    send(OP_REALLOC, 32'd0 + 8, 4);
    send(OP_REALLOC, 32'd8, 64);
    send(OP_ALLOC, 0, 4);
    send(OP_REALLOC, 32'd5, 4);
    send(OP_REALLOC, 32'd0, 24'hFFFFFF);

    setup(32'h0000_1000, 32'd4096, 32'd4);
    random_phase(100, 60);
    setup(32'hFFFF_F000, 32'd16777216, 32'd1024);
    random_phase(100, 85);
    setup(32'h8000_0000, 32'd600, 32'd2);
    random_phase(100, 55);
    setup(32'h1234_5678, 32'd16777215, 32'd2047);
    random_phase(100, 50);
    setup(32'h0000_0000, 32'd0, 32'd64);
    random_phase(30, 40);
    setup(32'hFFFF_FFFF, 32'd16777216, 32'd32);
    random_phase(50, 45);

    drain();
    if (errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_core.sv
sim/testbench.sv
